### sv/vbc_pkg.sv
// ----------------------------------------------------------------------------
// vbc_pkg
// Shared types, constants and alphabet maps for the Vigenere byte cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package vbc_pkg;

	localparam int KEY_DEPTH_DEF = 64;
	localparam int ALPHA_SIZE    = 118;
	localparam int POS_W         = 7;
	localparam int KIDX_W        = 6;
	localparam int KLEN_W        = 7;

	typedef enum logic {
		OP_KEY_WRITE = 1'b0,
		OP_TEXT      = 1'b1
	} opcode_t;

	typedef enum logic {
		CFG_MODE       = 1'b0,
		CFG_KEY_LENGTH = 1'b1
	} cfg_index_t;

	typedef enum logic {
		MODE_ENCRYPT = 1'b0,
		MODE_DECRYPT = 1'b1
	} mode_t;

	// text byte and the key byte it is paired with
	typedef struct packed {
		logic [7:0] text_byte;
		logic [7:0] key_byte;
	} pair_t;

	// byte to 1-based alphabet position, 0 when not a letter
	function automatic logic [POS_W-1:0] to_pos(input logic [7:0] b);
		logic [7:0] p;
		p = 8'd0;
		if (b >= 8'hE0 && b <= 8'hE5) p = b - 8'hE0 + 8'd1;
		else if (b == 8'hB8) p = 8'd7;
		else if (b >= 8'hE6) p = b - 8'hE6 + 8'd8;
		else if (b >= 8'hC0 && b <= 8'hC5) p = b - 8'hC0 + 8'd34;
		else if (b == 8'hA8) p = 8'd40;
		else if (b >= 8'hC6 && b <= 8'hDF) p = b - 8'hC6 + 8'd41;
		else if (b >= 8'h61 && b <= 8'h7A) p = b - 8'h61 + 8'd67;
		else if (b >= 8'h41 && b <= 8'h5A) p = b - 8'h41 + 8'd93;
		return p[POS_W-1:0];
	endfunction

	// alphabet position back to its byte
	function automatic logic [7:0] to_byte(input logic [POS_W-1:0] p);
		logic [7:0] pe;
		logic [7:0] b;
		pe = {1'b0, p};
		b  = 8'd0;
		if (pe >= 8'd1 && pe <= 8'd6) b = 8'hE0 + pe - 8'd1;
		else if (pe == 8'd7) b = 8'hB8;
		else if (pe >= 8'd8 && pe <= 8'd33) b = 8'hE6 + pe - 8'd8;
		else if (pe >= 8'd34 && pe <= 8'd39) b = 8'hC0 + pe - 8'd34;
		else if (pe == 8'd40) b = 8'hA8;
		else if (pe >= 8'd41 && pe <= 8'd66) b = 8'hC6 + pe - 8'd41;
		else if (pe >= 8'd67 && pe <= 8'd92) b = 8'h61 + pe - 8'd67;
		else if (pe >= 8'd93 && pe <= 8'd118) b = 8'h41 + pe - 8'd93;
		return b;
	endfunction

endpackage

`default_nettype wire

### sv/vbc_key_stage.sv
// ----------------------------------------------------------------------------
// vbc_key_stage
// Key store, rotating key pointer and the first pipeline register.
// ----------------------------------------------------------------------------
`default_nettype none

module vbc_key_stage #(
	parameter int KEY_DEPTH = vbc_pkg::KEY_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire vbc_pkg::opcode_t            opcode,
	input  wire logic [vbc_pkg::KIDX_W-1:0]  key_index,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        message_start,
	input  wire logic [vbc_pkg::KLEN_W-1:0]  key_length,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output vbc_pkg::pair_t                   pair
);
	import vbc_pkg::*;

	localparam int PTR_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int CNT_W = PTR_W + 1;
	localparam int LW    = (CNT_W > KLEN_W) ? CNT_W : KLEN_W;

	logic [7:0]       key_mem [KEY_DEPTH];
	logic [PTR_W-1:0] ptr_q;
	logic             valid_s1;
	pair_t            pair_s1;

	logic [LW-1:0] klen_w, len, cur, cur_inc, nxt, kidx_w;
	logic          accept, wr_en, rd_en;

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;
	assign wr_en    = accept && (opcode == OP_KEY_WRITE) && (kidx_w < LW'(KEY_DEPTH));
	assign rd_en    = accept && (opcode == OP_TEXT);
	assign kidx_w   = LW'(key_index);
	assign klen_w   = LW'(key_length);

	// clamp length to 1..KEY_DEPTH, pick slot, compute the next pointer
	always_comb begin
		if (klen_w == '0) len = LW'(1);
		else if (klen_w > LW'(KEY_DEPTH)) len = LW'(KEY_DEPTH);
		else len = klen_w;

		cur = message_start ? '0 : LW'(ptr_q);
		if (cur >= len) cur = '0;

		cur_inc = cur + LW'(1);
		nxt     = (cur_inc >= len) ? '0 : cur_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (rd_en) ptr_q <= nxt[PTR_W-1:0];
			if (in_ready) valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) key_mem[kidx_w[PTR_W-1:0]] <= data_byte;
		if (rd_en) begin
			pair_s1.key_byte  <= key_mem[cur[PTR_W-1:0]];
			pair_s1.text_byte <= data_byte;
		end
	end

	assign out_valid = valid_s1;
	assign pair      = pair_s1;

endmodule

`default_nettype wire

### sv/vbc_cipher_stage.sv
// ----------------------------------------------------------------------------
// vbc_cipher_stage
// Alphabet maps, mod-118 add or subtract, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vbc_cipher_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire vbc_pkg::pair_t pair,
	input  wire vbc_pkg::mode_t mode,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_byte,
	output logic                text_known,
	output logic                key_known
);
	import vbc_pkg::*;

	logic [POS_W-1:0] tp, kp, r;
	logic [POS_W:0]   sum;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             tknown_q, kknown_q;

	always_comb begin
		tp = to_pos(pair.text_byte);
		kp = to_pos(pair.key_byte);
		unique case (mode)
			MODE_ENCRYPT: sum = {1'b0, tp} + {1'b0, kp};
			MODE_DECRYPT: sum = {1'b0, tp} + (POS_W+1)'(ALPHA_SIZE) - {1'b0, kp};
			default:      sum = '0;
		endcase
		// sum <= 2*118, so one conditional subtract finishes the modulo
		if (sum >= (POS_W+1)'(ALPHA_SIZE)) r = POS_W'(sum - (POS_W+1)'(ALPHA_SIZE));
		else r = sum[POS_W-1:0];
		if (r == '0) r = POS_W'(ALPHA_SIZE);
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_q   <= to_byte(r);
			tknown_q <= (tp != '0);
			kknown_q <= (kp != '0);
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign text_known = tknown_q;
	assign key_known  = kknown_q;

endmodule

`default_nettype wire

### sv/vigenere_byte_cipher_core.sv
// ----------------------------------------------------------------------------
// vigenere_byte_cipher_core
// Vigenere cipher over a 118-letter Windows-1251 Cyrillic + Latin alphabet.
// ----------------------------------------------------------------------------
//
// channel | dir | payload
// --------+-----+-----------------------------------------------------------
// s_*     | in  | tuser: opcode; tdata: key_index, data_byte, message_start
// m_*     | out | tdata: out_byte; tuser: text_known, key_known
// cfg_*   | in  | cfg_index 0 = mode, 1 = key_length; no read-back
//
// Throughput is one word per cycle while m_tready does not stall. A text word
// passes through the registered key store read and then the alphabet maps and
// mod-118 arithmetic into the result register before it shows up on m_*.
// Key-store writes produce no output word. arst_n clears the pointer, the
// valid flags and the config registers (mode 0, key_length 1); the key store
// itself is not cleared. A stalled m_tready holds the result register and
// backs up into the key stage; s_tready drops only when both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module vigenere_byte_cipher_core #(
	parameter int KEY_DEPTH = vbc_pkg::KEY_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [15:0]                 s_tdata,   // key_index[5:0], data_byte[13:6],
	                                                    // message_start[14], zero[15]
	input  wire logic [0:0]                  s_tuser,   // opcode[0]

	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [7:0]                       m_tdata,   // out_byte[7:0]
	output logic [1:0]                       m_tuser,   // text_known[0], key_known[1]

	input  wire logic                        cfg_we,
	input  wire logic [0:0]                  cfg_index,
	input  wire logic [vbc_pkg::KLEN_W-1:0]  cfg_data
);
	import vbc_pkg::*;

	// config registers
	mode_t             mode_q;
	logic [KLEN_W-1:0] key_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ENCRYPT;
			key_length_q <= KLEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_MODE:       mode_q <= mode_t'(cfg_data[0]);
				CFG_KEY_LENGTH: key_length_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// input word unpack
	opcode_t           opcode;
	logic [KIDX_W-1:0] key_index;
	logic [7:0]        data_byte;
	logic              message_start;

	assign opcode        = opcode_t'(s_tuser[0]);
	assign key_index     = s_tdata[5:0];
	assign data_byte     = s_tdata[13:6];
	assign message_start = s_tdata[14];

	// stage 1 -> stage 2
	logic  valid_s1, ready_s1;
	pair_t pair_s1;

	vbc_key_stage #(
		.KEY_DEPTH(KEY_DEPTH)
	) u_key (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.opcode       (opcode),
		.key_index    (key_index),
		.data_byte    (data_byte),
		.message_start(message_start),
		.key_length   (key_length_q),
		.out_valid    (valid_s1),
		.out_ready    (ready_s1),
		.pair         (pair_s1)
	);

	logic text_known, key_known;

	vbc_cipher_stage u_cipher (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (ready_s1),
		.pair      (pair_s1),
		.mode      (mode_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.text_known(text_known),
		.key_known (key_known)
	);

	assign m_tuser = {key_known, text_known};

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vigenere_byte_cipher_core.
// Words are streamed in from a queue. Each accepted word goes through an
// in-bench cipher predictor. Output words are checked in order against the
// predicted results. Mode and key length change between drained phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import vbc_pkg::*;

	localparam int KEY_SLOTS   = KEY_DEPTH_DEF;
	localparam int HOLD_CYCLES = 200;      // one long output stall
	localparam int CYCLE_LIMIT = 300000;

	// one input word, split into its fields
	typedef struct {
		opcode_t    op;
		logic [5:0] slot;
		logic [7:0] data;
		logic       start;
	} word_t;

	// one output word
	typedef struct {
		logic [7:0] out_byte;
		logic       text_known;
		logic       key_known;
	} cipher_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;       // key_index[5:0], data_byte[13:6], message_start[14], zero[15]
	logic [0:0]  s_tuser = '0;       // opcode[0]

	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;            // out_byte[7:0]
	logic [1:0]  m_tuser;            // text_known[0], key_known[1]

	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [6:0]  cfg_data = '0;

	vigenere_byte_cipher_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Cipher predictor: shadow registers, key store and pointer
	// ------------------------------------------------------------------------
	mode_t       mode_reg = MODE_ENCRYPT;
	logic [6:0]  key_len_reg = 7'd1;
	logic [7:0]  key_mem [KEY_SLOTS];
	int unsigned key_ptr = 0;

	cipher_out_t expected_results [$];
	word_t       pending_words [$];
	word_t       cur_word;
	cipher_out_t head_result;

	logic [KEY_SLOTS-1:0] slot_loaded = '0;  // stimulus only: slots with a key byte
	int n_sent = 0;
	int n_taken = 0;
	int errors = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int cycles = 0;

	logic hold_req = 1'b0;
	int   hold_cnt;
	wire  sink_hold = hold_req && (hold_cnt < HOLD_CYCLES);

	// byte -> alphabet position 1..118, 0 for anything outside the alphabet
	function automatic int unsigned letter_pos(input logic [7:0] b);
		if (b >= 8'hE0 && b <= 8'hE5) return b - 8'hE0 + 1;       // a..ye
		if (b == 8'hB8) return 7;                                  // yo
		if (b >= 8'hE6) return b - 8'hE6 + 8;                      // zh..ya
		if (b >= 8'hC0 && b <= 8'hC5) return b - 8'hC0 + 34;      // A..YE
		if (b == 8'hA8) return 40;                                 // YO
		if (b >= 8'hC6 && b <= 8'hDF) return b - 8'hC6 + 41;      // ZH..YA
		if (b >= 8'h61 && b <= 8'h7A) return b - 8'h61 + 67;      // latin a..z
		if (b >= 8'h41 && b <= 8'h5A) return b - 8'h41 + 93;      // latin A..Z
		return 0;
	endfunction

	// position 1..118 -> byte
	function automatic logic [7:0] pos_letter(input int unsigned p);
		if (p <= 6) return 8'(8'hE0 + p - 1);
		if (p == 7) return 8'hB8;
		if (p <= 33) return 8'(8'hE6 + p - 8);
		if (p <= 39) return 8'(8'hC0 + p - 34);
		if (p == 40) return 8'hA8;
		if (p <= 66) return 8'(8'hC6 + p - 41);
		if (p <= 92) return 8'(8'h61 + p - 67);
		return 8'(8'h41 + p - 93);
	endfunction

	// one accepted word: key store write, or a text byte through the cipher
	task automatic apply_word(input word_t w);
		int unsigned len, p, tp, kp, r;
		cipher_out_t res;
		if (w.op == OP_KEY_WRITE) begin
			key_mem[w.slot] = w.data;
			return;
		end
		// zero length acts as one, oversize saturates at the store depth
		len = (key_len_reg == 0) ? 1 : (key_len_reg > KEY_SLOTS) ? KEY_SLOTS : key_len_reg;
		p = w.start ? 0 : key_ptr;
		if (p >= len)
			p = 0;   // length shrank under the pointer
		tp = letter_pos(w.data);
		kp = letter_pos(key_mem[p]);
		if (mode_reg == MODE_ENCRYPT)
			r = (tp + kp) % ALPHA_SIZE;
		else
			r = (tp + ALPHA_SIZE - kp) % ALPHA_SIZE;
		if (r == 0)
			r = ALPHA_SIZE;   // zero wraps to the last letter
		key_ptr = (p + 1 >= len) ? 0 : p + 1;
		res.out_byte   = pos_letter(r);
		res.text_known = (tp != 0);
		res.key_known  = (kp != 0);
		expected_results.push_back(res);
	endtask

	// ------------------------------------------------------------------------
	// Driver: offers words from the pending queue, idles at random
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_word(cur_word);
				n_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {1'b0, cur_word.start, cur_word.data, cur_word.slot};
					s_tuser  <= cur_word.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: checks each output word against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected word out_byte=%h tuser=%b", $time, m_tdata, m_tuser);
					errors++;
				end else begin
					head_result = expected_results.pop_front();
					if (m_tdata !== head_result.out_byte || m_tuser[0] !== head_result.text_known
							|| m_tuser[1] !== head_result.key_known) begin
						$display({"%0t: mismatch exp out_byte=%h text_known=%b key_known=%b,",
							" got out_byte=%h text_known=%b key_known=%b"},
							$time, head_result.out_byte, head_result.text_known,
							head_result.key_known, m_tdata, m_tuser[0], m_tuser[1]);
						errors++;
					end
				end
			end
			m_tready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// long output stall, counted once hold_req goes high
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_cnt <= 0;
		else if (hold_req && hold_cnt < HOLD_CYCLES)
			hold_cnt <= hold_cnt + 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL vigenere_byte_cipher_core");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic queue_word(input opcode_t op, input int slot, input logic [7:0] data,
			input logic start);
		word_t w;
		w.op    = op;
		w.slot  = slot[5:0];
		w.data  = data;
		w.start = start;
		if (op == OP_KEY_WRITE)
			slot_loaded[slot] = 1'b1;
		pending_words.push_back(w);
		n_sent++;
	endtask

	// letter with the given percent chance, else any byte
	function automatic logic [7:0] pick_byte(input int letter_pct);
		if ($urandom_range(99) < letter_pct)
			return pos_letter($urandom_range(ALPHA_SIZE, 1));
		return 8'($urandom_range(255));
	endfunction

	// all words taken, all results back, pipeline flushed
	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_taken != n_sent || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [6:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == CFG_MODE)
			mode_reg = mode_t'(val[0]);
		else
			key_len_reg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input mode_t md, input logic [6:0] len, input int n_words,
			input int src_pct, input int snk_pct);
		int eff;
		wait_drained();
		write_reg(CFG_MODE, 7'(md));
		write_reg(CFG_KEY_LENGTH, len);
		eff = (len == 0) ? 1 : (len > KEY_SLOTS) ? KEY_SLOTS : len;
		@(negedge clk);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		// every slot the pointer can reach gets a key byte before any text
		for (int s = 0; s < eff; s++)
			if (!slot_loaded[s])
				queue_word(OP_KEY_WRITE, s, pick_byte(90), 1'b0);
		for (int i = 0; i < n_words; i++) begin
			if ($urandom_range(99) < 15)
				queue_word(OP_KEY_WRITE, $urandom_range(KEY_SLOTS - 1), pick_byte(80),
					1'($urandom_range(1)));
			else
				queue_word(OP_TEXT, $urandom_range(KEY_SLOTS - 1), pick_byte(70),
					$urandom_range(99) < 8);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset config: encrypt, key length 1
		@(negedge clk);
		src_idle_pct = 23;
		snk_idle_pct = 63;
		queue_word(OP_KEY_WRITE, 0, 8'hFF, 1'b0);      // key = ya
		queue_word(OP_KEY_WRITE, 63, 8'h41, 1'b1);     // top slot
		queue_word(OP_TEXT, 0, 8'h00, 1'b1);           // text outside alphabet
		queue_word(OP_TEXT, 0, 8'h73, 1'b0);           // sum hits 118, wraps
		queue_word(OP_TEXT, 0, 8'hFF, 1'b0);
		queue_word(OP_TEXT, 0, 8'h5A, 1'b0);           // last letter, mod wrap
		queue_word(OP_TEXT, 0, 8'hB8, 1'b0);           // yo
		queue_word(OP_TEXT, 0, 8'hA8, 1'b0);           // YO
		queue_word(OP_TEXT, 0, 8'hE5, 1'b0);
		queue_word(OP_TEXT, 0, 8'hE6, 1'b0);
		queue_word(OP_TEXT, 0, 8'hC5, 1'b0);
		queue_word(OP_TEXT, 0, 8'hC6, 1'b0);
		queue_word(OP_TEXT, 0, 8'h7A, 1'b0);
		queue_word(OP_TEXT, 0, 8'h40, 1'b0);
		queue_word(OP_TEXT, 0, 8'h5B, 1'b0);
		queue_word(OP_KEY_WRITE, 0, 8'h20, 1'b0);      // key outside alphabet
		queue_word(OP_TEXT, 0, 8'h41, 1'b0);
		queue_word(OP_TEXT, 0, 8'h7F, 1'b0);           // both unknown

		// directed decrypt
		wait_drained();
		write_reg(CFG_MODE, 7'(MODE_DECRYPT));
		@(negedge clk);
		queue_word(OP_KEY_WRITE, 0, 8'h61, 1'b0);
		queue_word(OP_TEXT, 0, 8'h61, 1'b1);           // difference zero
		queue_word(OP_TEXT, 0, 8'h00, 1'b0);
		queue_word(OP_TEXT, 0, 8'hFF, 1'b0);           // negative difference

		// random phases across mode and length settings
		run_phase(MODE_ENCRYPT, 7'd64, 300, 23, 63);
		run_phase(MODE_DECRYPT, 7'd5, 300, 63, 23);
		run_phase(MODE_DECRYPT, 7'd0, 100, 63, 23);    // zero length acts as one
		@(negedge clk);
		hold_req <= 1'b1;                              // input backs up behind the stall
		run_phase(MODE_ENCRYPT, 7'd127, 150, 0, 0);    // saturates at store depth
		run_phase(MODE_ENCRYPT, 7'd1, 100, 0, 0);
		run_phase(MODE_DECRYPT, 7'd64, 200, 0, 0);
		run_phase(MODE_ENCRYPT, 7'd17, 100, 0, 0);     // shrink under a live pointer
		wait_drained();

		if (errors == 0)
			$display("PASS vigenere_byte_cipher_core");
		else
			$display("FAIL vigenere_byte_cipher_core");
		$finish;
	end

endmodule

`default_nettype wire

### vigenere_byte_cipher_core.f
sv/vbc_pkg.sv
sv/vbc_key_stage.sv
sv/vbc_cipher_stage.sv
sv/vigenere_byte_cipher_core.sv
sim/tb_top.sv
